FILE: rtl/gttd_pkg.sv
`default_nettype none

package gttd_pkg;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW      = $clog2(QueueDepth);
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

  localparam logic [7:0] CMD_COLUMN   = 8'h2A;
  localparam logic [7:0] CMD_ROW      = 8'h2B;
  localparam logic [7:0] CMD_MEMWRITE = 8'h2C;
  localparam logic [7:0] SPACE_CODE   = 8'h20;

  localparam logic [4:0]  FONT_WIDTH_RST  = 5'd11;
  localparam logic [5:0]  FONT_HEIGHT_RST = 6'd18;
  localparam logic [15:0] FG_COLOR_RST    = 16'hFFFF;
  localparam logic [15:0] BG_COLOR_RST    = 16'h0000;

  localparam logic [4:0] MAX_WIDTH  = 5'd16;
  localparam logic [5:0] MAX_HEIGHT = 6'd32;

  typedef enum logic [1:0] {
    FUNC_START = 2'd0,
    FUNC_CHAR  = 2'd1,
    FUNC_ROW   = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    CFG_FONT_WIDTH  = 2'd0,
    CFG_FONT_HEIGHT = 2'd1,
    CFG_FG_COLOR    = 2'd2,
    CFG_BG_COLOR    = 2'd3
  } cfg_reg_e;

  typedef enum logic {
    JOB_WINDOW = 1'b0,
    JOB_PIXELS = 1'b1
  } job_e;

  typedef struct packed {
    logic [1:0]  func;
    logic [8:0]  start_x;
    logic [8:0]  start_y;
    logic [7:0]  char_code;
    logic [15:0] row_bits;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_data;
    logic       last;
  } out_item_t;

  typedef struct packed {
    job_e        kind;
    logic [15:0] col_s;
    logic [15:0] col_e;
    logic [15:0] row_s;
    logic [15:0] row_e;
    logic [15:0] row_bits;
    logic [4:0]  width;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

`default_nettype wire

FILE: rtl/gttd_front.sv
`default_nettype none

module gttd_front #(
  parameter int unsigned DISPLAY_WIDTH  = 240,
  parameter int unsigned DISPLAY_HEIGHT = 240,
  parameter int unsigned X_OFFSET       = 0,
  parameter int unsigned Y_OFFSET       = 0
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  input  wire gttd_pkg::in_item_t  in_i,
  output logic                     in_stall_o,
  input  wire logic [4:0]          font_width_i,
  input  wire logic [5:0]          font_height_i,
  input  wire gttd_pkg::q_status_t q_status_i,
  output logic                     push_o,
  output gttd_pkg::job_t           job_o
);
  import gttd_pkg::*;

  localparam logic [10:0] DispW = 11'(DISPLAY_WIDTH);
  localparam logic [10:0] DispH = 11'(DISPLAY_HEIGHT);
  localparam logic [15:0] XOff  = 16'(X_OFFSET);
  localparam logic [15:0] YOff  = 16'(Y_OFFSET);

  logic [9:0]  cursor_x_q, cursor_x_d;
  logic [9:0]  cursor_y_q, cursor_y_d;
  logic        halted_q, halted_d;
  logic        active_q, active_d;
  logic [5:0]  rows_q, rows_d;

  logic        accept;
  logic [4:0]  w_eff;
  logic [5:0]  h_eff;
  logic [10:0] x_sum;
  logic [9:0]  y_wrap;
  logic [10:0] y_sum;
  logic        wrap;
  logic        bottom;
  logic [9:0]  x_use;
  logic [9:0]  y_use;
  logic [5:0]  rows_inc;

  always_comb begin
    if (font_width_i == 5'd0) begin
      w_eff = 5'd1;
    end else if (font_width_i > MAX_WIDTH) begin
      w_eff = MAX_WIDTH;
    end else begin
      w_eff = font_width_i;
    end
    if (font_height_i == 6'd0) begin
      h_eff = 6'd1;
    end else if (font_height_i > MAX_HEIGHT) begin
      h_eff = MAX_HEIGHT;
    end else begin
      h_eff = font_height_i;
    end
  end

  assign in_stall_o = q_status_i.full;
  assign accept     = in_valid_i && !in_stall_o;

  assign x_sum    = {1'b0, cursor_x_q} + 11'(w_eff);
  assign wrap     = x_sum >= DispW;
  assign y_wrap   = cursor_y_q + 10'(h_eff);
  assign y_sum    = {1'b0, y_wrap} + 11'(h_eff);
  assign bottom   = y_sum >= DispH;
  assign x_use    = wrap ? 10'd0 : cursor_x_q;
  assign y_use    = wrap ? y_wrap : cursor_y_q;
  assign rows_inc = rows_q + 6'd1;

  always_comb begin
    job_o.kind     = JOB_WINDOW;
    job_o.col_s    = 16'(x_use) + XOff;
    job_o.col_e    = 16'(x_use) + 16'(w_eff) - 16'd1 + XOff;
    job_o.row_s    = 16'(y_use) + YOff;
    job_o.row_e    = 16'(y_use) + 16'(h_eff) - 16'd1 + YOff;
    job_o.row_bits = in_i.row_bits;
    job_o.width    = w_eff;
    push_o         = 1'b0;
    cursor_x_d     = cursor_x_q;
    cursor_y_d     = cursor_y_q;
    halted_d       = halted_q;
    active_d       = active_q;
    rows_d         = rows_q;
    if (accept) begin
      unique case (in_i.func)
        FUNC_START: begin
          cursor_x_d = {1'b0, in_i.start_x};
          cursor_y_d = {1'b0, in_i.start_y};
          halted_d   = 1'b0;
          active_d   = 1'b0;
          rows_d     = 6'd0;
        end
        FUNC_CHAR: begin
          if (halted_q) begin
            active_d = 1'b0;
          end else begin
            if (wrap) begin
              cursor_x_d = 10'd0;
              cursor_y_d = y_wrap;
            end
            if (wrap && bottom) begin
              halted_d = 1'b1;
              active_d = 1'b0;
            end else if (wrap && in_i.char_code == SPACE_CODE) begin
              active_d = 1'b0;
            end else begin
              push_o     = 1'b1;
              cursor_x_d = x_use + 10'(w_eff);
              active_d   = 1'b1;
              rows_d     = 6'd0;
            end
          end
        end
        FUNC_ROW: begin
          if (!halted_q && active_q && rows_q < h_eff) begin
            job_o.kind = JOB_PIXELS;
            push_o     = 1'b1;
            rows_d     = rows_inc;
            if (rows_inc >= h_eff) begin
              active_d = 1'b0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_x_q <= '0;
      cursor_y_q <= '0;
      halted_q   <= 1'b0;
      active_q   <= 1'b0;
      rows_q     <= '0;
    end else begin
      cursor_x_q <= cursor_x_d;
      cursor_y_q <= cursor_y_d;
      halted_q   <= halted_d;
      active_q   <= active_d;
      rows_q     <= rows_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/gttd_queue.sv
`default_nettype none

module gttd_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire gttd_pkg::job_t job_i,
  input  wire logic           pop_i,
  output gttd_pkg::job_t      head_o,
  output gttd_pkg::q_status_t status_o
);
  import gttd_pkg::*;

  job_t             mem_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] count_q, count_d;

  assign head_o         = mem_q[rd_ptr_q];
  assign status_o.full  = count_q == QCntW'(QueueDepth);
  assign status_o.empty = count_q == '0;

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + QCntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + QPtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + QPtrW'(1);
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/gttd_back.sv
`default_nettype none

module gttd_back (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire gttd_pkg::job_t      head_i,
  input  wire gttd_pkg::q_status_t q_status_i,
  output logic                     pop_o,
  input  wire logic [15:0]         fg_color_i,
  input  wire logic [15:0]         bg_color_i,
  output logic                     out_valid_o,
  output gttd_pkg::out_item_t      out_o,
  input  wire logic                out_stall_i
);
  import gttd_pkg::*;

  localparam logic [4:0] WinLastIdx = 5'd10;

  logic        out_valid_q, out_valid_d;
  out_item_t   out_q, out_d;
  logic [4:0]  idx_q, idx_d;
  logic        load;
  logic [4:0]  pix_last;
  logic [3:0]  pix_col;
  logic [15:0] color;
  out_item_t   win_item;

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  assign load     = (!out_valid_q || !out_stall_i) && !q_status_i.empty;
  assign pix_last = 5'({head_i.width, 1'b0} - 6'd1);
  assign pix_col  = idx_q[4:1];
  assign color    = head_i.row_bits[4'd15 - pix_col] ? fg_color_i : bg_color_i;

  always_comb begin
    win_item.is_data = 1'b1;
    win_item.last    = 1'b0;
    case (idx_q)
      5'd0: begin
        win_item.out_byte = CMD_COLUMN;
        win_item.is_data  = 1'b0;
      end
      5'd1: win_item.out_byte = head_i.col_s[15:8];
      5'd2: win_item.out_byte = head_i.col_s[7:0];
      5'd3: win_item.out_byte = head_i.col_e[15:8];
      5'd4: win_item.out_byte = head_i.col_e[7:0];
      5'd5: begin
        win_item.out_byte = CMD_ROW;
        win_item.is_data  = 1'b0;
      end
      5'd6: win_item.out_byte = head_i.row_s[15:8];
      5'd7: win_item.out_byte = head_i.row_s[7:0];
      5'd8: win_item.out_byte = head_i.row_e[15:8];
      5'd9: win_item.out_byte = head_i.row_e[7:0];
      default: begin
        win_item.out_byte = CMD_MEMWRITE;
        win_item.is_data  = 1'b0;
        win_item.last     = 1'b1;
      end
    endcase
  end

  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q;
    idx_d       = idx_q;
    pop_o       = 1'b0;
    if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (load) begin
      out_valid_d = 1'b1;
      if (head_i.kind == JOB_WINDOW) begin
        out_d = win_item;
        pop_o = idx_q == WinLastIdx;
      end else begin
        out_d.out_byte = idx_q[0] ? color[7:0] : color[15:8];
        out_d.is_data  = 1'b1;
        out_d.last     = idx_q == pix_last;
        pop_o          = idx_q == pix_last;
      end
      idx_d = pop_o ? 5'd0 : idx_q + 5'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/glyph_text_to_display_bytes.sv
// Text to display-controller byte stream. A start item places the cursor; a character
// item yields 11 bytes (column window, row window, memory-write command) or none when
// skipped or halted; a glyph row item yields 2 * font_width pixel bytes (width clamped
// to 1..16), high byte first, or none when halted or no active glyph has rows left.
// The front end takes one item per clock while its two-entry job queue has room; the
// back end sends one byte per clock through its output register while not stalled.
// Write configuration only while no bytes are pending.
`default_nettype none

module glyph_text_to_display_bytes #(
  parameter int unsigned DISPLAY_WIDTH  = 240,
  parameter int unsigned DISPLAY_HEIGHT = 240,
  parameter int unsigned X_OFFSET       = 0,
  parameter int unsigned Y_OFFSET       = 0
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  input  wire gttd_pkg::in_item_t  in_i,
  output logic                     in_stall_o,
  output logic                     out_valid_o,
  output gttd_pkg::out_item_t      out_o,
  input  wire logic                out_stall_i,
  input  wire logic                cfg_we_i,
  input  wire logic [1:0]          cfg_idx_i,
  input  wire logic [15:0]         cfg_wdata_i
);
  import gttd_pkg::*;

  logic [4:0]  font_width_q;
  logic [5:0]  font_height_q;
  logic [15:0] fg_color_q;
  logic [15:0] bg_color_q;

  logic      push;
  logic      pop;
  job_t      job;
  job_t      head;
  q_status_t q_status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      font_width_q  <= FONT_WIDTH_RST;
      font_height_q <= FONT_HEIGHT_RST;
      fg_color_q    <= FG_COLOR_RST;
      bg_color_q    <= BG_COLOR_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_FONT_WIDTH:  font_width_q  <= cfg_wdata_i[4:0];
        CFG_FONT_HEIGHT: font_height_q <= cfg_wdata_i[5:0];
        CFG_FG_COLOR:    fg_color_q    <= cfg_wdata_i;
        CFG_BG_COLOR:    bg_color_q    <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  gttd_front #(
    .DISPLAY_WIDTH  (DISPLAY_WIDTH),
    .DISPLAY_HEIGHT (DISPLAY_HEIGHT),
    .X_OFFSET       (X_OFFSET),
    .Y_OFFSET       (Y_OFFSET)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_i          (in_i),
    .in_stall_o    (in_stall_o),
    .font_width_i  (font_width_q),
    .font_height_i (font_height_q),
    .q_status_i    (q_status),
    .push_o        (push),
    .job_o         (job)
  );

  gttd_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .job_i    (job),
    .pop_i    (pop),
    .head_o   (head),
    .status_o (q_status)
  );

  gttd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .q_status_i  (q_status),
    .pop_o       (pop),
    .fg_color_i  (fg_color_q),
    .bg_color_i  (bg_color_q),
    .out_valid_o (out_valid_o),
    .out_o       (out_o),
    .out_stall_i (out_stall_i)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni) push |-> !q_status.full)
    else $error("job pushed into full queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni) pop |-> !q_status.empty)
    else $error("job popped from empty queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!q_status.empty && !out_valid_o) |=> out_valid_o)
    else $error("pending job not moved to output register");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> (out_valid_o && out_o.last))
    else $error("job finished without last byte");

endmodule

`default_nettype wire

FILE: tb/glyph_stream_checker.sv
`timescale 1ns / 1ps

module glyph_stream_checker import gttd_pkg::*; #(
  parameter int DISPLAY_WIDTH  = 240,
  parameter int DISPLAY_HEIGHT = 240,
  parameter int X_OFFSET       = 0,
  parameter int Y_OFFSET       = 0
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  in_item_t         in_item_i,
  input  wire logic        in_stall_i,
  input  wire logic        out_valid_i,
  input  out_item_t        out_item_i,
  input  wire logic        out_stall_i,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_wdata_i,
  output int               mismatch_count_o,
  output int               bytes_pending_o
);

  logic [4:0]  font_w_q;
  logic [5:0]  font_h_q;
  logic [15:0] fg_q;
  logic [15:0] bg_q;
  logic [9:0]  col_q;
  logic [9:0]  line_q;
  logic        halt_q;
  logic        glyph_q;
  logic [5:0]  rows_q;
  int          err_count = 0;
  out_item_t   expected_bytes_q[$];

  task automatic push_byte(logic [7:0] value, logic data, logic tail);
    out_item_t b;
    b.out_byte = value;
    b.is_data  = data;
    b.last     = tail;
    expected_bytes_q.push_back(b);
  endtask

  task automatic push_window(logic [7:0] cmd, int lo_pos, int hi_pos);
    logic [15:0] s;
    logic [15:0] e;
    s = 16'(lo_pos);
    e = 16'(hi_pos);
    push_byte(cmd, 1'b0, 1'b0);
    push_byte(s[15:8], 1'b1, 1'b0);
    push_byte(s[7:0], 1'b1, 1'b0);
    push_byte(e[15:8], 1'b1, 1'b0);
    push_byte(e[7:0], 1'b1, 1'b0);
  endtask

  task automatic rasterize_item(in_item_t it);
    int          w;
    int          h;
    int          col;
    int          line;
    logic        skip;
    logic [15:0] pixel;
    w = (font_w_q == 0) ? 1 : (font_w_q > MAX_WIDTH) ? int'(MAX_WIDTH) : int'(font_w_q);
    h = (font_h_q == 0) ? 1 : (font_h_q > MAX_HEIGHT) ? int'(MAX_HEIGHT) : int'(font_h_q);
    case (it.func)
      FUNC_START: begin
        col_q   = {1'b0, it.start_x};
        line_q  = {1'b0, it.start_y};
        halt_q  = 1'b0;
        glyph_q = 1'b0;
        rows_q  = '0;
      end
      FUNC_CHAR: begin
        skip = 1'b0;
        if (halt_q) begin
          glyph_q = 1'b0;
          skip    = 1'b1;
        end else if (int'(col_q) + w >= DISPLAY_WIDTH) begin
          col_q  = '0;
          line_q = 10'(int'(line_q) + h);
          if (int'(line_q) + h >= DISPLAY_HEIGHT) begin
            halt_q  = 1'b1;
            glyph_q = 1'b0;
            skip    = 1'b1;
          end else if (it.char_code == SPACE_CODE) begin
            glyph_q = 1'b0;
            skip    = 1'b1;
          end
        end
        if (!skip) begin
          col  = int'(col_q);
          line = int'(line_q);
          push_window(CMD_COLUMN, col + X_OFFSET, col + w - 1 + X_OFFSET);
          push_window(CMD_ROW, line + Y_OFFSET, line + h - 1 + Y_OFFSET);
          push_byte(CMD_MEMWRITE, 1'b0, 1'b1);
          col_q   = 10'(int'(col_q) + w);
          glyph_q = 1'b1;
          rows_q  = '0;
        end
      end
      FUNC_ROW: begin
        if (!halt_q && glyph_q && int'(rows_q) < h) begin
          for (int j = 0; j < w; j++) begin
            pixel = it.row_bits[15 - j] ? fg_q : bg_q;
            push_byte(pixel[15:8], 1'b1, 1'b0);
            push_byte(pixel[7:0], 1'b1, j == w - 1);
          end
          rows_q = rows_q + 6'd1;
          if (int'(rows_q) >= h) glyph_q = 1'b0;
        end
      end
      default: ;
    endcase
  endtask

  task automatic match_display_byte(out_item_t got);
    out_item_t exp;
    if (expected_bytes_q.size() == 0) begin
      err_count++;
      $error("unexpected transfer: out_byte %02h is_data %0b last %0b",
             got.out_byte, got.is_data, got.last);
    end else begin
      exp = expected_bytes_q.pop_front();
      if (got.out_byte !== exp.out_byte) begin
        err_count++;
        $error("out_byte: expected %02h, actual %02h", exp.out_byte, got.out_byte);
      end
      if (got.is_data !== exp.is_data) begin
        err_count++;
        $error("is_data: expected %0b, actual %0b", exp.is_data, got.is_data);
      end
      if (got.last !== exp.last) begin
        err_count++;
        $error("last: expected %0b, actual %0b", exp.last, got.last);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      font_w_q = FONT_WIDTH_RST;
      font_h_q = FONT_HEIGHT_RST;
      fg_q     = FG_COLOR_RST;
      bg_q     = BG_COLOR_RST;
      col_q    = '0;
      line_q   = '0;
      halt_q   = 1'b0;
      glyph_q  = 1'b0;
      rows_q   = '0;
      expected_bytes_q.delete();
      mismatch_count_o <= err_count;
      bytes_pending_o  <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_FONT_WIDTH:  font_w_q = cfg_wdata_i[4:0];
          CFG_FONT_HEIGHT: font_h_q = cfg_wdata_i[5:0];
          CFG_FG_COLOR:    fg_q     = cfg_wdata_i;
          CFG_BG_COLOR:    bg_q     = cfg_wdata_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) rasterize_item(in_item_i);
      if (out_valid_i && !out_stall_i) match_display_byte(out_item_i);
      mismatch_count_o <= err_count;
      bytes_pending_o  <= expected_bytes_q.size();
    end
  end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import gttd_pkg::*;

  localparam int DISPLAY_WIDTH  = 240;
  localparam int DISPLAY_HEIGHT = 240;
  localparam int X_OFFSET       = 0;
  localparam int Y_OFFSET       = 0;

  localparam logic [1:0] FUNC_UNUSED  = 2'd3;
  localparam int         RANDOM_ITEMS = 370;
  localparam int         PHASE_ITEMS  = 40;
  localparam int         SETTLE       = 32;
  localparam int         CYCLE_LIMIT  = 3000000;

  logic        clk_i     = 1'b0;
  logic        rst_ni    = 1'b0;
  logic        in_valid  = 1'b0;
  in_item_t    in_item   = '0;
  logic        in_stall;
  logic        out_valid;
  out_item_t   out_item;
  logic        out_stall = 1'b0;
  logic        cfg_we    = 1'b0;
  logic [1:0]  cfg_idx   = '0;
  logic [15:0] cfg_wdata = '0;

  int          mismatches;
  int          bytes_pending;
  int          items_sent  = 0;
  int          glyph_rows  = 18;
  int          in_calm     = 0;
  int          out_calm    = 0;
  int          stall_left  = 0;
  int unsigned cycle_count = 0;

  glyph_text_to_display_bytes #(
    .DISPLAY_WIDTH (DISPLAY_WIDTH),
    .DISPLAY_HEIGHT(DISPLAY_HEIGHT),
    .X_OFFSET      (X_OFFSET),
    .Y_OFFSET      (Y_OFFSET)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_i       (in_item),
    .in_stall_o (in_stall),
    .out_valid_o(out_valid),
    .out_o      (out_item),
    .out_stall_i(out_stall),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  glyph_stream_checker #(
    .DISPLAY_WIDTH (DISPLAY_WIDTH),
    .DISPLAY_HEIGHT(DISPLAY_HEIGHT),
    .X_OFFSET      (X_OFFSET),
    .Y_OFFSET      (Y_OFFSET)
  ) u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_item_i       (in_item),
    .in_stall_i      (in_stall),
    .out_valid_i     (out_valid),
    .out_item_i      (out_item),
    .out_stall_i     (out_stall),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .mismatch_count_o(mismatches),
    .bytes_pending_o (bytes_pending)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(13, 40);
  endfunction

  always @(posedge clk_i) begin : stall_gen
    int len;
    if (!rst_ni) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (out_stall) begin
      out_stall  <= 1'b0;
      stall_left <= $urandom_range(0, 6);
    end else begin
      len = pick_gap(out_calm);
      if (len != 0) begin
        out_stall  <= 1'b1;
        stall_left <= len - 1;
      end
    end
  end

  function automatic in_item_t random_item();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[$bits(in_item_t)-1:0];
  endfunction

  function automatic in_item_t mk(logic [1:0] f, logic [8:0] x, logic [8:0] y,
                                  logic [7:0] code, logic [15:0] bits);
    in_item_t it;
    it.func      = f;
    it.start_x   = x;
    it.start_y   = y;
    it.char_code = code;
    it.row_bits  = bits;
    return it;
  endfunction

  task automatic send_item(in_item_t it);
    int gap;
    gap = pick_gap(in_calm);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    if (it.func != FUNC_UNUSED) items_sent++;
  endtask

  task automatic wait_idle();
    @(posedge clk_i);
    while (bytes_pending != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [15:0] value);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(posedge clk_i);
  endtask

  task automatic load_font(logic [15:0] w_word, logic [15:0] h_word,
                           logic [15:0] fg, logic [15:0] bg);
    write_reg(CFG_FONT_WIDTH, w_word);
    write_reg(CFG_FONT_HEIGHT, h_word);
    write_reg(CFG_FG_COLOR, fg);
    write_reg(CFG_BG_COLOR, bg);
    cfg_we <= 1'b0;
    glyph_rows = (h_word[5:0] == 0) ? 1 : (h_word[5:0] > 32) ? 32 : int'(h_word[5:0]);
  endtask

  // place the cursor, then characters each followed by their glyph rows
  task automatic send_text(int phase_end);
    in_item_t it;
    int       n_chars;
    int       n_rows;
    int       r;
    it = random_item();
    it.func = FUNC_START;
    if ($urandom_range(0, 7) != 0) begin
      it.start_x = 9'($urandom_range(0, DISPLAY_WIDTH - 1));
      it.start_y = 9'($urandom_range(0, DISPLAY_HEIGHT - 1));
    end
    send_item(it);
    n_chars = $urandom_range(1, 8);
    for (int i = 0; i < n_chars && items_sent < phase_end; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        it = random_item();
        it.func = $urandom_range(0, 1) ? FUNC_UNUSED : FUNC_ROW;
        send_item(it);
      end
      it = random_item();
      it.func = FUNC_CHAR;
      if ($urandom_range(0, 3) == 0) it.char_code = SPACE_CODE;
      send_item(it);
      r = $urandom_range(0, 7);
      if (r == 0) n_rows = $urandom_range(0, glyph_rows);
      else if (r == 1) n_rows = glyph_rows + $urandom_range(1, 2);
      else n_rows = glyph_rows;
      for (int k = 0; k < n_rows && items_sent < phase_end; k++) begin
        it = random_item();
        it.func = FUNC_ROW;
        send_item(it);
      end
    end
  endtask

  initial begin
    logic [15:0] w_word;
    logic [15:0] h_word;
    int          target;
    int          phase_end;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_item(mk(FUNC_UNUSED, 9'd511, 9'd511, 8'hFF, 16'hFFFF));
    send_item(mk(FUNC_ROW, 9'd0, 9'd0, 8'h00, 16'hFFFF));
    send_item(mk(FUNC_START, 9'd0, 9'd0, 8'h00, 16'h0000));
    send_item(mk(FUNC_CHAR, 9'd0, 9'd0, 8'h41, 16'h0000));
    send_item(mk(FUNC_ROW, 9'd0, 9'd0, 8'h00, 16'hFFFF));
    send_item(mk(FUNC_ROW, 9'd511, 9'd511, 8'hFF, 16'h0000));
    send_item(mk(FUNC_ROW, 9'd0, 9'd0, 8'h00, 16'hA5C3));
    send_item(mk(FUNC_CHAR, 9'd0, 9'd0, 8'hFF, 16'h0000));
    send_item(mk(FUNC_ROW, 9'd0, 9'd0, 8'h00, 16'h8001));
    send_item(mk(FUNC_START, 9'd229, 9'd0, 8'h00, 16'h0000));
    send_item(mk(FUNC_CHAR, 9'd0, 9'd0, SPACE_CODE, 16'h0000));
    send_item(mk(FUNC_ROW, 9'd0, 9'd0, 8'h00, 16'hFFFF));
    send_item(mk(FUNC_CHAR, 9'd0, 9'd0, SPACE_CODE, 16'h0000));
    send_item(mk(FUNC_START, 9'd228, 9'd200, 8'h00, 16'h0000));
    send_item(mk(FUNC_CHAR, 9'd0, 9'd0, 8'h00, 16'h0000));
    send_item(mk(FUNC_CHAR, 9'd0, 9'd0, 8'h7F, 16'h0000));
    send_item(mk(FUNC_START, 9'd235, 9'd204, 8'h00, 16'h0000));
    send_item(mk(FUNC_CHAR, 9'd0, 9'd0, 8'h42, 16'h0000));
    send_item(mk(FUNC_ROW, 9'd0, 9'd0, 8'h00, 16'hFFFF));
    send_item(mk(FUNC_CHAR, 9'd0, 9'd0, 8'h43, 16'h0000));
    send_item(mk(FUNC_START, 9'd511, 9'd511, 8'h00, 16'h0000));
    send_item(mk(FUNC_CHAR, 9'd0, 9'd0, 8'h44, 16'h0000));
    send_item(mk(FUNC_START, 9'd0, 9'd511, 8'h00, 16'h0000));
    send_item(mk(FUNC_CHAR, 9'd0, 9'd0, 8'h45, 16'h0000));
    send_item(mk(FUNC_ROW, 9'd0, 9'd0, 8'h00, 16'h7FFE));
    send_item(mk(FUNC_START, 9'd0, 9'd0, 8'h00, 16'h0000));
    send_item(mk(FUNC_ROW, 9'd0, 9'd0, 8'h00, 16'hFFFF));

    target = items_sent + RANDOM_ITEMS;
    for (int phase = 0; items_sent < target; phase++) begin
      in_valid <= 1'b0;
      wait_idle();
      w_word = 16'($urandom);
      h_word = 16'($urandom);
      case (phase)
        0: begin
          w_word[4:0] = 5'd1;
          h_word[5:0] = 6'd1;
          load_font(w_word, h_word, 16'h0000, 16'hFFFF);
        end
        1: begin
          w_word[4:0] = 5'd16;
          h_word[5:0] = 6'd32;
          load_font(w_word, h_word, 16'($urandom), 16'($urandom));
        end
        2: begin
          w_word[4:0] = 5'd0;
          h_word[5:0] = 6'd0;
          load_font(w_word, h_word, 16'hFFFF, 16'h0000);
        end
        3: load_font(16'hFFFF, 16'hFFFF, 16'($urandom), 16'($urandom));
        default: begin
          w_word[4:0] = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(0, 31))
                                                   : 5'($urandom_range(1, 16));
          h_word[5:0] = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(0, 63))
                                                   : 6'($urandom_range(1, 6));
          load_font(w_word, h_word, 16'($urandom), 16'($urandom));
        end
      endcase
      phase_end = (items_sent + PHASE_ITEMS < target) ? items_sent + PHASE_ITEMS : target;
      while (items_sent < phase_end) send_text(phase_end);
    end

    in_valid <= 1'b0;
    wait_idle();
    if (mismatches == 0 && bytes_pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
